// ===== hdl/run_lumi_range_filter_unit_defines.svh =====
// assertion macros shared by the run/lumi range filter rtl
`ifndef RUN_LUMI_RANGE_FILTER_UNIT_DEFINES_SVH
`define RUN_LUMI_RANGE_FILTER_UNIT_DEFINES_SVH

// clocked check, disabled while reset is asserted
`define RLRF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define RLRF_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/rlrf_pkg.sv =====
// shared types and constants of the run/lumi range filter
package rlrf_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;
	localparam int RUN_W = 32;
	localparam int LUMI_W = 32;
	localparam int BOUND_W = 33;
	localparam int OP_W = 2;

	localparam logic [OP_W-1:0] OP_QUERY = 2'd0;
	localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	localparam logic signed [BOUND_W-1:0] BOUND_NONE = '1;

	// one stored table entry
	typedef struct packed {
		logic [RUN_W-1:0] run;
		logic signed [BOUND_W-1:0] low;
		logic signed [BOUND_W-1:0] high;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== hdl/rlrf_if.sv =====
// valid/ready channel interfaces for items and results
interface rlrf_in_if import rlrf_pkg::*; ();
	logic valid;
	logic ready;
	logic [OP_W-1:0] opcode;
	logic [RUN_W-1:0] run_number;
	logic [LUMI_W-1:0] lumi_number;
	logic signed [BOUND_W-1:0] range_low;
	logic signed [BOUND_W-1:0] range_high;

	modport source (output valid, opcode, run_number, lumi_number, range_low, range_high,
		input ready);
	modport sink (input valid, opcode, run_number, lumi_number, range_low, range_high,
		output ready);
endinterface

interface rlrf_out_if import rlrf_pkg::*; ();
	logic valid;
	logic ready;
	logic accepted;
	logic status;
	logic signed [BOUND_W-1:0] lowest_run;
	logic signed [BOUND_W-1:0] lowest_run_low_lumi;
	logic signed [BOUND_W-1:0] highest_run;
	logic signed [BOUND_W-1:0] highest_run_high_lumi;

	modport source (output valid, accepted, status, lowest_run, lowest_run_low_lumi,
		highest_run, highest_run_high_lumi, input ready);
	modport sink (input valid, accepted, status, lowest_run, lowest_run_low_lumi,
		highest_run, highest_run_high_lumi, output ready);
endinterface

// ===== hdl/rlrf_ram.sv =====
// generic single write port ram with one registered read port
module rlrf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/run_lumi_range_filter_unit.sv =====
// run/lumi good-range table: insert, clear and query with run summary
// Keeps up to TABLE_ENTRIES good (run, lumi range) entries in one entry ram.
// Every transaction on item yields exactly one transaction on result.
// Insert, clear, unused opcodes and a query against an empty table finish in
// the cycle they are taken, with the result valid in the next cycle. A query
// against a filled table reads the entry ram one entry per cycle from the
// oldest entry on, as its single read port allows, and stops at the first hit
// or after the last entry, with the result registered when it stops.
// A new item is taken once the unit is back from a scan and the result
// register is empty or being drained in the same cycle. The entry ram needs
// no clearing pass: only the first entry_count entries are ever read, so a
// clear just resets the count and the run summary. The run summary (smallest
// run with its first lower bound, largest run with its last upper bound) is
// held in flip-flops and reported with every result as it stands after the
// item's own action, or all ones when the table is empty.
`include "run_lumi_range_filter_unit_defines.svh"

module run_lumi_range_filter_unit import rlrf_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input logic clk,
	input logic arst_n,
	rlrf_in_if.sink item,
	rlrf_out_if.source result
);

	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

	// scan sequencer states
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic state_q;

	// table summary
	logic [CW-1:0] count_q;
	logic [RUN_W-1:0] min_run_q;
	logic signed [BOUND_W-1:0] min_low_q;
	logic [RUN_W-1:0] max_run_q;
	logic signed [BOUND_W-1:0] max_high_q;

	logic [CW-1:0] nxt_count;
	logic [RUN_W-1:0] nxt_min_run;
	logic signed [BOUND_W-1:0] nxt_min_low;
	logic [RUN_W-1:0] nxt_max_run;
	logic signed [BOUND_W-1:0] nxt_max_high;

	// query scan
	logic [RUN_W-1:0] qrun_q;
	logic [LUMI_W-1:0] qlumi_q;
	logic [AW-1:0] addr_q;
	logic issue_q;
	logic pend_s1;
	logic last_s1;

	// result register
	logic out_valid_q;
	logic acc_q;
	logic status_q;
	logic signed [BOUND_W-1:0] low_run_q;
	logic signed [BOUND_W-1:0] low_lumi_q;
	logic signed [BOUND_W-1:0] high_run_q;
	logic signed [BOUND_W-1:0] high_lumi_q;

	logic take;
	logic is_query;
	logic is_insert;
	logic is_clear;
	logic table_empty;
	logic table_full;
	logic ins_ok;
	logic start_scan;
	logic load_now;
	logic rd_en;
	logic scan_last;
	logic hit;
	logic scan_done;
	logic signed [BOUND_W-1:0] lumi_s;
	entry_t wr_entry;
	entry_t rd_entry;

	// new item only between scans and with room in the result register
	assign item.ready = (state_q == ST_IDLE) && (!out_valid_q || result.ready);
	assign take = item.valid && item.ready;

	assign is_query = (item.opcode == OP_QUERY);
	assign is_insert = (item.opcode == OP_INSERT);
	assign is_clear = (item.opcode == OP_CLEAR);
	assign table_empty = (count_q == '0);
	assign table_full = (count_q == FULL_COUNT);
	assign ins_ok = take && is_insert && !table_full;

	// a query against a filled table walks the entry ram, anything else ends now
	assign start_scan = take && is_query && !table_empty;
	assign load_now = take && !start_scan;

	// entry ram: appended at count, read by the scan only, never both at once
	assign wr_entry = '{run: item.run_number, low: item.range_low, high: item.range_high};
	assign rd_en = (state_q == ST_SCAN) && issue_q;

	rlrf_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_ENTRIES)
	) u_entry_ram (
		.clk   (clk),
		.we    (ins_ok),
		.waddr (count_q[AW-1:0]),
		.wdata (wr_entry),
		.re    (rd_en),
		.raddr (addr_q),
		.rdata (rd_entry)
	);

	// match check on the entry read back in the cycle after its address
	assign scan_last = (CW'(addr_q) == (count_q - CW'(1)));
	assign lumi_s = $signed({1'b0, qlumi_q});
	assign hit = pend_s1 && (rd_entry.run == qrun_q) && (rd_entry.low <= lumi_s)
		&& ((rd_entry.high == BOUND_NONE) || (rd_entry.high >= lumi_s));
	assign scan_done = pend_s1 && (hit || last_s1);

	// summary after this cycle's item
	always_comb begin
		nxt_count = count_q;
		nxt_min_run = min_run_q;
		nxt_min_low = min_low_q;
		nxt_max_run = max_run_q;
		nxt_max_high = max_high_q;
		if (take && is_clear) begin
			nxt_count = '0;
			nxt_min_run = '0;
			nxt_min_low = BOUND_NONE;
			nxt_max_run = '0;
			nxt_max_high = BOUND_NONE;
		end else if (ins_ok) begin
			nxt_count = count_q + CW'(1);
			// earliest entry wins a tie on the smallest run
			if (table_empty || (item.run_number < min_run_q)) begin
				nxt_min_run = item.run_number;
				nxt_min_low = item.range_low;
			end
			// latest entry wins a tie on the largest run
			if (table_empty || (item.run_number >= max_run_q)) begin
				nxt_max_run = item.run_number;
				nxt_max_high = item.range_high;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			min_run_q <= '0;
			min_low_q <= BOUND_NONE;
			max_run_q <= '0;
			max_high_q <= BOUND_NONE;
		end else begin
			count_q <= nxt_count;
			min_run_q <= nxt_min_run;
			min_low_q <= nxt_min_low;
			max_run_q <= nxt_max_run;
			max_high_q <= nxt_max_high;
		end
	end

	// scan sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			addr_q <= '0;
			issue_q <= 1'b0;
			pend_s1 <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			pend_s1 <= rd_en && !scan_done;
			last_s1 <= scan_last;
			case (state_q)
				ST_IDLE: begin
					if (start_scan) begin
						state_q <= ST_SCAN;
						addr_q <= '0;
						issue_q <= 1'b1;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						addr_q <= addr_q + AW'(1);
						if (scan_last) begin
							issue_q <= 1'b0;
						end
					end
					if (scan_done) begin
						state_q <= ST_IDLE;
						issue_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					issue_q <= 1'b0;
				end
			endcase
		end
	end

	// query operands held for the length of the scan
	always_ff @(posedge clk) begin
		if (start_scan) begin
			qrun_q <= item.run_number;
			qlumi_q <= item.lumi_number;
		end
	end

	// result register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_now || scan_done) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, summary taken after the item's own action
	always_ff @(posedge clk) begin
		if (load_now || scan_done) begin
			// an empty table accepts every query
			acc_q <= load_now ? is_query : hit;
			status_q <= load_now && is_insert && table_full;
			if (nxt_count == '0) begin
				low_run_q <= BOUND_NONE;
				low_lumi_q <= BOUND_NONE;
				high_run_q <= BOUND_NONE;
				high_lumi_q <= BOUND_NONE;
			end else begin
				low_run_q <= $signed({1'b0, nxt_min_run});
				low_lumi_q <= nxt_min_low;
				high_run_q <= $signed({1'b0, nxt_max_run});
				high_lumi_q <= nxt_max_high;
			end
		end
	end

	assign result.valid = out_valid_q;
	assign result.accepted = acc_q;
	assign result.status = status_q;
	assign result.lowest_run = low_run_q;
	assign result.lowest_run_low_lumi = low_lumi_q;
	assign result.highest_run = high_run_q;
	assign result.highest_run_high_lumi = high_lumi_q;

	`RLRF_ASSERT(a_count_bound, count_q <= FULL_COUNT, "entry count above table size")
	`RLRF_ASSERT(a_scan_holds_output, (state_q == ST_SCAN) |-> !out_valid_q, "result busy during scan")
	`RLRF_ASSERT(a_scan_ends_in_result, (state_q == ST_SCAN) && scan_done |=> out_valid_q && (state_q == ST_IDLE), "scan end without result")
	`RLRF_ASSERT(a_full_drop, take && is_insert && table_full |=> (count_q == FULL_COUNT) && status_q, "full insert not dropped")
	`RLRF_ASSERT(a_clear_empties, take && is_clear |=> (count_q == '0) && (low_run_q == BOUND_NONE), "clear left entries")

endmodule
